FILE: rtl/cds_pkg.sv
// Shared types, widths and constants for the calendar date stepper.
`default_nettype none

package cds_pkg;

    // Field widths.
    localparam int YEAR_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int ORDER_W  = 2;

    // Date held after reset.
    localparam logic [DAY_W-1:0]   RESET_DAY   = DAY_W'(1);
    localparam logic [MONTH_W-1:0] RESET_MONTH = MONTH_W'(1);
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = YEAR_W'(2000);

    // Month codes.
    localparam logic [MONTH_W-1:0] M_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] M_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] M_MAR = MONTH_W'(3);
    localparam logic [MONTH_W-1:0] M_APR = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] M_MAY = MONTH_W'(5);
    localparam logic [MONTH_W-1:0] M_JUN = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] M_JUL = MONTH_W'(7);
    localparam logic [MONTH_W-1:0] M_AUG = MONTH_W'(8);
    localparam logic [MONTH_W-1:0] M_SEP = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] M_OCT = MONTH_W'(10);
    localparam logic [MONTH_W-1:0] M_NOV = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] M_DEC = MONTH_W'(12);

    // Month lengths.
    localparam logic [DAY_W-1:0] LEN_LONG  = DAY_W'(31);
    localparam logic [DAY_W-1:0] LEN_SHORT = DAY_W'(30);
    localparam logic [DAY_W-1:0] LEN_LEAP  = DAY_W'(29);
    localparam logic [DAY_W-1:0] LEN_FEB   = DAY_W'(28);
    localparam logic [DAY_W-1:0] LEN_NONE  = DAY_W'(0);

    // Divisibility by 25 through the multiplicative inverse modulo 2^16:
    // y is a multiple of 25 exactly when (y * INV25) mod 2^16 <= DIV25_MAX.
    localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(23593);
    localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(2621);

    // Commands.
    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_SUB  = 2'd1,
        CMD_LOAD = 2'd2,
        CMD_CMP  = 2'd3
    } t_cmd;

    // Comparison results.
    localparam logic [ORDER_W-1:0] ORD_LESS    = ORDER_W'(0);
    localparam logic [ORDER_W-1:0] ORD_EQUAL   = ORDER_W'(1);
    localparam logic [ORDER_W-1:0] ORD_GREATER = ORDER_W'(2);

    // Request to the date unit: command, stored date and supplied date.
    typedef struct packed {
        t_cmd               cmd;
        logic [DAY_W-1:0]   cur_day;
        logic [MONTH_W-1:0] cur_month;
        logic [YEAR_W-1:0]  cur_year;
        logic [DAY_W-1:0]   arg_day;
        logic [MONTH_W-1:0] arg_month;
        logic [YEAR_W-1:0]  arg_year;
    } t_alu_req;

    // Answer of the date unit.
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               invalid;
        logic [ORDER_W-1:0] order;
    } t_alu_rsp;

endpackage

`default_nettype wire

FILE: rtl/calendar_date_stepper_unit.sv
// Top level of the calendar date stepper: command sequencer and result register.
//
//  Channel   Direction  Signals                 Contents (lowest bit first)
//  s_axis    in         tvalid tready tdata     day_count, day_in, month_in, year_in
//                       tuser                   cmd
//  m_axis    out        tvalid tready tdata     day_out, month_out, year_out,
//                                               date_invalid, order
//
// A load or a compare finishes in the execute state after its transfer: its result
// is posted as the input opens again. An add or a subtract steps the date one day
// per cycle through the shared date unit, then finishes the same way.
// s_axis_tready is high only while the sequencer is idle.
// A result waits in the output register, so the next command is taken while
// it is not yet accepted; a full output register holds the finish step.
// Synchronous active-low reset sets the date to 1/1/2000 and empties the output.
`default_nettype none

module calendar_date_stepper_unit
    import cds_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // day_count, day_in, month_in, year_in, zero pad
    input  wire logic [1:0]  s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // day_out, month_out, year_out, date_invalid,
                                            // order, zero pad
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state             r_state,     n_state;
    t_cmd               r_cmd,       n_cmd;
    logic [COUNT_W-1:0] r_count,     n_count;
    logic [DAY_W-1:0]   r_arg_day,   n_arg_day;
    logic [MONTH_W-1:0] r_arg_month, n_arg_month;
    logic [YEAR_W-1:0]  r_arg_year,  n_arg_year;
    logic [DAY_W-1:0]   r_day,       n_day;
    logic [MONTH_W-1:0] r_month,     n_month;
    logic [YEAR_W-1:0]  r_year,      n_year;
    logic               r_out_valid, n_out_valid;
    logic [DAY_W-1:0]   r_out_day,   n_out_day;
    logic [MONTH_W-1:0] r_out_month, n_out_month;
    logic [YEAR_W-1:0]  r_out_year,  n_out_year;
    logic               r_out_inv,   n_out_inv;
    logic [ORDER_W-1:0] r_out_order, n_out_order;

    logic     s_xfer;
    logic     out_free;
    logic     stepping;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_xfer        = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~r_out_valid | m_axis_tready;
    assign stepping      = (r_state == S_EXEC) && (r_cmd == CMD_ADD || r_cmd == CMD_SUB)
                        && (r_count != '0);

    // Shared date unit sees the stored date and the captured command.
    assign alu_req.cmd       = r_cmd;
    assign alu_req.cur_day   = r_day;
    assign alu_req.cur_month = r_month;
    assign alu_req.cur_year  = r_year;
    assign alu_req.arg_day   = r_arg_day;
    assign alu_req.arg_month = r_arg_month;
    assign alu_req.arg_year  = r_arg_year;

    cds_date_alu u_date_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Sequencer: capture a command, step one day per cycle, then post the result.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_arg_day   = r_arg_day;
        n_arg_month = r_arg_month;
        n_arg_year  = r_arg_year;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_day   = r_out_day;
        n_out_month = r_out_month;
        n_out_year  = r_out_year;
        n_out_inv   = r_out_inv;
        n_out_order = r_out_order;
        unique case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    n_cmd       = t_cmd'(s_axis_tuser);
                    n_count     = s_axis_tdata[15:0];
                    n_arg_day   = s_axis_tdata[20:16];
                    n_arg_month = s_axis_tdata[24:21];
                    n_arg_year  = s_axis_tdata[40:25];
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stepping) begin
                    n_day   = alu_rsp.day;
                    n_month = alu_rsp.month;
                    n_year  = alu_rsp.year;
                    n_count = r_count - COUNT_W'(1);
                end else if (out_free) begin
                    // Finish: loads and compares take the unit's date, steps are done.
                    if (r_cmd == CMD_LOAD || r_cmd == CMD_CMP) begin
                        n_day       = alu_rsp.day;
                        n_month     = alu_rsp.month;
                        n_year      = alu_rsp.year;
                        n_out_day   = alu_rsp.day;
                        n_out_month = alu_rsp.month;
                        n_out_year  = alu_rsp.year;
                    end else begin
                        n_out_day   = r_day;
                        n_out_month = r_month;
                        n_out_year  = r_year;
                    end
                    n_out_inv   = alu_rsp.invalid;
                    n_out_order = alu_rsp.order;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    // State, stored date and output register.
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_count     <= n_count;
        r_arg_day   <= n_arg_day;
        r_arg_month <= n_arg_month;
        r_arg_year  <= n_arg_year;
        r_out_day   <= n_out_day;
        r_out_month <= n_out_month;
        r_out_year  <= n_out_year;
        r_out_inv   <= n_out_inv;
        r_out_order <= n_out_order;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_day       <= RESET_DAY;
            r_month     <= RESET_MONTH;
            r_year      <= RESET_YEAR;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_day       <= n_day;
            r_month     <= n_month;
            r_year      <= n_year;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_order, r_out_inv, r_out_year, r_out_month,
                            r_out_day};

`ifndef SYNTHESIS
    // The stored month never leaves January to December.
    a_month_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_month >= M_JAN) && (r_month <= M_DEC))
        else $error("stored month out of range");

    // A new command closes the input until its result is posted.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // Each step cycle consumes exactly one day of the count.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stepping |=> (r_count == COUNT_W'($past(r_count) - COUNT_W'(1))))
        else $error("day count did not advance by one");

    // A rejected load leaves the stored date untouched.
    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && (r_cmd == CMD_LOAD) && out_free && alu_rsp.invalid)
        |=> ($stable(r_day) && $stable(r_month) && $stable(r_year)))
        else $error("rejected load changed the date");

    // An invalid flag only comes with a load, which reports no order.
    a_invalid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_inv) |-> (r_out_order == ORD_LESS))
        else $error("invalid result carries an order");
`endif

endmodule

`default_nettype wire

FILE: rtl/cds_month_len.sv
// Month length lookup with the Gregorian leap-year rule.
`default_nettype none

module cds_month_len
    import cds_pkg::*;
(
    input  wire logic [MONTH_W-1:0] i_month,
    input  wire logic [YEAR_W-1:0]  i_year,
    output logic      [DAY_W-1:0]   o_len
);

    logic [2*YEAR_W-1:0] full_prod;
    logic [YEAR_W-1:0]   inv_prod;
    logic                div4;
    logic                div16;
    logic                div25;
    logic                leap;

    // Multiple of 25 test by modular inverse; 4 and 16 come from low bits.
    assign full_prod = {{YEAR_W{1'b0}}, i_year} * {{YEAR_W{1'b0}}, INV25};
    assign inv_prod  = full_prod[YEAR_W-1:0];
    assign div25     = (inv_prod <= DIV25_MAX);
    assign div4      = (i_year[1:0] == 2'b00);
    assign div16     = (i_year[3:0] == 4'b0000);

    // Leap when divisible by 4 and not 100, or by 400 (400 = 16 * 25).
    assign leap = div4 & (~div25 | div16);

    // Length of the month; an illegal month code has length zero.
    always_comb begin
        unique case (i_month)
            M_JAN, M_MAR, M_MAY, M_JUL, M_AUG, M_OCT, M_DEC: o_len = LEN_LONG;
            M_APR, M_JUN, M_SEP, M_NOV:                      o_len = LEN_SHORT;
            M_FEB:   o_len = leap ? LEN_LEAP : LEN_FEB;
            default: o_len = LEN_NONE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/cds_date_alu.sv
// Shared date unit: one day step forward or back, load check and compare.
`default_nettype none

module cds_date_alu
    import cds_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic [MONTH_W-1:0] prev_month;
    logic [YEAR_W-1:0]  prev_year;
    logic [MONTH_W-1:0] len_month;
    logic [YEAR_W-1:0]  len_year;
    logic [DAY_W-1:0]   len;
    logic [DAY_W:0]     day_inc;
    logic [MONTH_W:0]   month_inc;
    logic               load_ok;
    logic [YEAR_W+MONTH_W+DAY_W-1:0] cur_key;
    logic [YEAR_W+MONTH_W+DAY_W-1:0] arg_key;

    // Previous month, wrapping to December of the year before.
    assign prev_month = (i_req.cur_month <= M_JAN) ? M_DEC
                                                   : i_req.cur_month - MONTH_W'(1);
    assign prev_year  = (i_req.cur_month <= M_JAN) ? i_req.cur_year - YEAR_W'(1)
                                                   : i_req.cur_year;

    // One length lookup serves every command. A backward step into December
    // takes 31 days whatever the year, so the stored year is enough there.
    always_comb begin
        unique case (i_req.cmd)
            CMD_SUB:  len_month = prev_month;
            CMD_LOAD: len_month = i_req.arg_month;
            default:  len_month = i_req.cur_month;
        endcase
        len_year = (i_req.cmd == CMD_LOAD) ? i_req.arg_year : i_req.cur_year;
    end

    cds_month_len u_month_len (
        .i_month (len_month),
        .i_year  (len_year),
        .o_len   (len)
    );

    assign day_inc   = {1'b0, i_req.cur_day} + (DAY_W+1)'(1);
    assign month_inc = {1'b0, i_req.cur_month} + (MONTH_W+1)'(1);

    // A load is taken only with a legal month and a day inside that month.
    assign load_ok = (i_req.arg_month >= M_JAN) && (i_req.arg_month <= M_DEC)
                  && (i_req.arg_day != '0) && (i_req.arg_day <= len);

    // Year, then month, then day, compared as raw numbers.
    assign cur_key = {i_req.cur_year, i_req.cur_month, i_req.cur_day};
    assign arg_key = {i_req.arg_year, i_req.arg_month, i_req.arg_day};

    always_comb begin
        o_rsp.day     = i_req.cur_day;
        o_rsp.month   = i_req.cur_month;
        o_rsp.year    = i_req.cur_year;
        o_rsp.invalid = 1'b0;
        o_rsp.order   = ORD_LESS;
        unique case (i_req.cmd)
            CMD_ADD: begin
                // Forward one day with month and year rollover.
                if (day_inc > {1'b0, len}) begin
                    o_rsp.day = RESET_DAY;
                    if (month_inc > {1'b0, M_DEC}) begin
                        o_rsp.month = M_JAN;
                        o_rsp.year  = i_req.cur_year + YEAR_W'(1);
                    end else begin
                        o_rsp.month = month_inc[MONTH_W-1:0];
                    end
                end else begin
                    o_rsp.day = day_inc[DAY_W-1:0];
                end
            end
            CMD_SUB: begin
                // Back one day; the first of a month goes to the last of the prior one.
                if (i_req.cur_day <= RESET_DAY) begin
                    o_rsp.month = prev_month;
                    o_rsp.year  = prev_year;
                    o_rsp.day   = len;
                end else begin
                    o_rsp.day = i_req.cur_day - DAY_W'(1);
                end
            end
            CMD_LOAD: begin
                if (load_ok) begin
                    o_rsp.day   = i_req.arg_day;
                    o_rsp.month = i_req.arg_month;
                    o_rsp.year  = i_req.arg_year;
                end else begin
                    o_rsp.invalid = 1'b1;
                end
            end
            CMD_CMP: begin
                if (cur_key > arg_key) begin
                    o_rsp.order = ORD_GREATER;
                end else if (cur_key == arg_key) begin
                    o_rsp.order = ORD_EQUAL;
                end else begin
                    o_rsp.order = ORD_LESS;
                end
            end
        endcase
    end

endmodule

`default_nettype wire
